// ===== hdl/crps_pkg.sv =====
package crps_pkg;

   localparam int MaxEntries = 16;
   localparam int IdxW = 4;
   localparam int CntW = 5;
   localparam int KeyW = 8;
   localparam int StampW = 32;
   localparam int SeenDepth = 256;

   localparam logic [1:0] POL_FIFO  = 2'd0;
   localparam logic [1:0] POL_LRU   = 2'd1;
   localparam logic [1:0] POL_CLOCK = 2'd2;

   localparam logic [1:0] KIND_HIT  = 2'd0;
   localparam logic [1:0] KIND_COMP = 2'd1;
   localparam logic [1:0] KIND_CAP  = 2'd2;

   localparam logic CSR_POLICY  = 1'b0;
   localparam logic CSR_ENTRIES = 1'b1;

   // One word handed from cell to cell along the scan chain.
   typedef struct packed {
      logic              found;
      logic [IdxW-1:0]   pos;
      logic [StampW-1:0] best_stamp;
      logic [IdxW-1:0]   best_idx;
   } scan_type;

endpackage

// ===== hdl/crps_cell.sv =====
module crps_cell
   import crps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic [IdxW-1:0]   my_idx,
   input  logic              in_range,
   input  logic [KeyW-1:0]   key,
   input  scan_type          scan_in,
   output scan_type          scan_out,
   input  logic              wr_en,
   input  logic              wr_stamp_en,
   input  logic [StampW-1:0] wr_stamp,
   input  logic              ref_set,
   input  logic              ref_clr,
   output logic              ref_bit
);

   logic [KeyW-1:0]   key_ff;
   logic              valid_ff;
   logic [StampW-1:0] stamp_ff;
   logic              ref_ff;

   assign ref_bit = ref_ff;

   // A cell inside the active range joins the match search and the stamp minimum.
   always_comb begin
      scan_out = scan_in;
      if (in_range) begin
         if (!scan_in.found && valid_ff && key_ff == key) begin
            scan_out.found = 1'b1;
            scan_out.pos   = my_idx;
         end
         if (stamp_ff < scan_in.best_stamp) begin
            scan_out.best_stamp = stamp_ff;
            scan_out.best_idx   = my_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         key_ff <= key;
      if (reset || clear) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
         ref_ff   <= 1'b0;
      end else begin
         if (wr_en)
            valid_ff <= 1'b1;
         if (wr_stamp_en)
            stamp_ff <= wr_stamp;
         if (ref_set)
            ref_ff <= 1'b1;
         else if (ref_clr)
            ref_ff <= 1'b0;
      end
   end

endmodule

// ===== hdl/cache_replacement_policy_sim.sv =====
// Fully associative cache model over byte keys with FIFO, LRU or clock replacement.
// Input: an access is transferred when req_start is high and req_busy is low.
// Output: rsp_valid pulses for one cycle with hit, miss kind and both saturating
// miss counts; the receiver cannot stall, so every result is taken when shown.
// Configuration: csr_valid/csr_ready write register csr_index (0 policy,
// 1 entries in use); any write to a listed register clears all cache state.
// The csr port is ready whenever no access is in flight.
// Sequence: after the access transfer the scan visits one cell per cycle along
// the chain over all MaxEntries cells, then picks and updates the victim,
// marks the key as seen in ST_SEEN, counts in ST_DONE and then raises rsp_valid.
// A clock-policy miss first steps the hand, clearing each set reference bit
// it meets, then fills the entry whose bit is clear. req_busy falls as
// rsp_valid rises, so the next access can be transferred on the edge that takes the result.
// The seen-key bitmap is a 256 x 1 memory; after reset or a register write a
// clearing pass over all 256 entries runs before accesses are taken.
module cache_replacement_policy_sim
   import crps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  logic [7:0]  req_access_key,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [1:0]  rsp_miss_kind,
   output logic [31:0] rsp_compulsory_count,
   output logic [31:0] rsp_capacity_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_HAND  = 6'b001000,
      ST_SEEN  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        policy_ff;
   logic [CntW-1:0]   entries_ff;
   logic [KeyW-1:0]   key_ff;
   logic [CntW-1:0]   step_ff;
   scan_type          acc_ff;
   logic [IdxW-1:0]   hand_ff;
   logic [StampW-1:0] stamp_ctr_ff;
   logic [31:0]       comp_ff, cap_ff;
   logic              seen_mem [SeenDepth];
   logic              seen_rd_ff;
   logic [KeyW-1:0]   clr_addr_ff;
   logic              hit_ff;
   logic [1:0]        kind_ff;
   logic              clear_cells;

   logic [CntW-1:0]   n_act;
   logic [MaxEntries-1:0] ref_bits;
   scan_type          chain [MaxEntries+1];
   logic [MaxEntries-1:0] wr_en, wr_stamp_en, ref_set, ref_clr;
   logic [IdxW-1:0]   hand_eff;
   logic [IdxW-1:0]   hand_next;
   logic [StampW-1:0] stamp_next;
   logic              cfg_wr;

   assign n_act = (entries_ff == '0) ? CntW'(1) :
                  (entries_ff > CntW'(MaxEntries)) ? CntW'(MaxEntries) : entries_ff;
   assign req_busy  = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) || (state_ff == ST_CLEAR);
   assign cfg_wr    = csr_valid && csr_ready;
   assign clear_cells = cfg_wr;
   assign stamp_next = (stamp_ctr_ff == '1) ? stamp_ctr_ff : stamp_ctr_ff + 1'b1;
   assign hand_eff  = ({1'b0, hand_ff} >= n_act) ? '0 : hand_ff;
   assign hand_next = ({1'b0, hand_ff} + 1'b1 >= n_act) ? '0 : hand_ff + 1'b1;

   // The chain carries the running match and minimum; one cell's result is
   // captured per cycle, so the scan crosses the row one cell at a time.
   assign chain[0] = acc_ff;

   genvar g;
   generate
      for (g = 0; g < MaxEntries; g++) begin : g_cell
         scan_type cell_out;
         crps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .clear      (clear_cells),
            .my_idx     (IdxW'(g)),
            .in_range   (CntW'(g) < n_act && step_ff == CntW'(g)),
            .key        (key_ff),
            .scan_in    (acc_ff),
            .scan_out   (cell_out),
            .wr_en      (wr_en[g]),
            .wr_stamp_en(wr_stamp_en[g]),
            .wr_stamp   (stamp_next),
            .ref_set    (ref_set[g]),
            .ref_clr    (ref_clr[g]),
            .ref_bit    (ref_bits[g])
         );
         assign chain[g+1] = (step_ff == CntW'(g)) ? cell_out : chain[g];
      end
   endgenerate

   always_comb begin
      wr_en = '0;
      wr_stamp_en = '0;
      ref_set = '0;
      ref_clr = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_addr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:  if (req_start) state_in = ST_SCAN;
         ST_SCAN: begin
            if (step_ff == CntW'(MaxEntries)) begin
               if (policy_ff == POL_LRU) begin
                  if (acc_ff.found) begin
                     wr_en[acc_ff.pos] = 1'b1;
                     wr_stamp_en[acc_ff.pos] = 1'b1;
                  end else begin
                     wr_en[acc_ff.best_idx] = 1'b1;
                     wr_stamp_en[acc_ff.best_idx] = 1'b1;
                  end
                  state_in = ST_SEEN;
               end else if (policy_ff == POL_CLOCK) begin
                  if (acc_ff.found) begin
                     ref_set[acc_ff.pos] = 1'b1;
                     state_in = ST_SEEN;
                  end else begin
                     state_in = ST_HAND;
                  end
               end else begin
                  if (!acc_ff.found) begin
                     wr_en[acc_ff.best_idx] = 1'b1;
                     wr_stamp_en[acc_ff.best_idx] = 1'b1;
                  end
                  state_in = ST_SEEN;
               end
            end
         end
         ST_HAND: begin
            if (ref_bits[hand_eff]) begin
               ref_clr[hand_eff] = 1'b1;
            end else begin
               wr_en[hand_eff] = 1'b1;
               ref_set[hand_eff] = 1'b1;
               state_in = ST_SEEN;
            end
         end
         ST_SEEN: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
      if (cfg_wr)
         state_in = ST_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR)
         seen_mem[clr_addr_ff] <= 1'b0;
      else if (state_ff == ST_SEEN)
         seen_mem[key_ff] <= 1'b1;
      seen_rd_ff <= seen_mem[key_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_start)
         key_ff <= req_access_key;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         policy_ff    <= POL_FIFO;
         entries_ff   <= CntW'(MaxEntries);
         clr_addr_ff  <= '0;
         step_ff      <= '0;
         hand_ff      <= '0;
         stamp_ctr_ff <= '0;
         comp_ff      <= '0;
         cap_ff       <= '0;
         rsp_valid    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= 1'b0;
         if (state_ff == ST_CLEAR)
            clr_addr_ff <= clr_addr_ff + 1'b1;
         case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               acc_ff.found      <= 1'b0;
               acc_ff.pos        <= '0;
               acc_ff.best_stamp <= '1;
               acc_ff.best_idx   <= '0;
            end
            ST_SCAN: begin
               if (step_ff != CntW'(MaxEntries)) begin
                  acc_ff  <= chain[MaxEntries];
                  step_ff <= step_ff + 1'b1;
               end
               if (step_ff == CntW'(MaxEntries) && policy_ff != POL_CLOCK &&
                   (policy_ff == POL_LRU || !acc_ff.found))
                  stamp_ctr_ff <= stamp_next;
               if (step_ff == CntW'(MaxEntries) && policy_ff == POL_CLOCK && !acc_ff.found)
                  hand_ff <= hand_eff;
            end
            ST_HAND: begin
               if (ref_bits[hand_eff])
                  hand_ff <= hand_next;
               else
                  hand_ff <= hand_eff;
            end
            ST_DONE: begin
               rsp_valid <= 1'b1;
               hit_ff    <= acc_ff.found;
               if (acc_ff.found)
                  kind_ff <= KIND_HIT;
               else if (seen_rd_ff) begin
                  kind_ff <= KIND_CAP;
                  if (cap_ff != '1) cap_ff <= cap_ff + 1'b1;
               end else begin
                  kind_ff <= KIND_COMP;
                  if (comp_ff != '1) comp_ff <= comp_ff + 1'b1;
               end
            end
            default: ;
         endcase
         if (cfg_wr) begin
            if (csr_index == CSR_POLICY)
               policy_ff <= csr_wdata[1:0];
            else
               entries_ff <= csr_wdata;
            clr_addr_ff  <= '0;
            hand_ff      <= '0;
            stamp_ctr_ff <= '0;
            comp_ff      <= '0;
            cap_ff       <= '0;
         end
      end
   end

   assign rsp_hit              = hit_ff;
   assign rsp_miss_kind        = kind_ff;
   assign rsp_compulsory_count = comp_ff;
   assign rsp_capacity_count   = cap_ff;

`ifndef NO_ASSERTIONS
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held over two cycles");
   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (rsp_miss_kind == KIND_HIT)))
      else $error("hit and miss kind disagree");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_busy) else $error("access taken while clearing");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_en)) else $error("more than one cell written");
`endif

endmodule
